### rtl/dda_pkg.sv
package dda_pkg;

  // Coordinate and fixed-point geometry
  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 16;
  localparam int ACC_BITS   = COORD_BITS + FRAC_BITS + 1;
  localparam int QUO_BITS   = COORD_BITS + FRAC_BITS;
  localparam int REG_BITS   = COORD_BITS + 1;
  localparam int CNT_BITS   = $clog2(QUO_BITS + 1);

  // Configuration port
  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SCREEN_HEIGHT = 2'd1;
  localparam logic [REG_BITS-1:0] SCREEN_RESET = REG_BITS'(1024);

  // Round-half-up bias for the y accumulator
  localparam logic [ACC_BITS-1:0] HALF_LSB = ACC_BITS'(1) << (FRAC_BITS - 1);

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } dda_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_done;
  } dda_stat_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  visible;
    logic                  last;
    logic                  line_active;
  } dda_result_t;

endpackage

### rtl/dda_if.sv
interface dda_in_if import dda_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  opcode;
  logic [COORD_BITS-1:0] first_x;
  logic [COORD_BITS-1:0] first_y;
  logic [COORD_BITS-1:0] second_x;
  logic [COORD_BITS-1:0] second_y;

  modport source (output valid, opcode, first_x, first_y, second_x, second_y,
                  input ready);
  modport sink (input valid, opcode, first_x, first_y, second_x, second_y,
                output ready);
endinterface

interface dda_out_if import dda_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic                  visible;
  logic                  last;
  logic                  line_active;

  modport source (output valid, pixel_x, pixel_y, visible, last, line_active,
                  input ready);
  modport sink (input valid, pixel_x, pixel_y, visible, last, line_active,
                output ready);
endinterface

### rtl/dda_line_rasterizer.sv
// Channel   Role    Word
// cmd       sink    opcode, first_x, first_y, second_x, second_y
// pix       source  pixel_x, pixel_y, visible, last, line_active
// cfg_*     write   cfg_index selects screen_width (0) or screen_height (1)
//
// Each step word gives one output word; pixels stream one per cycle through
// the output register while pix is ready. A load word waits on the restoring
// slope divider, which retires one quotient bit per cycle over 28 bits.
// Reset is synchronous; it clears the line and sets both screen sizes to 1024.
// A stalled pix channel holds its word and stops cmd once the register is full.
module dda_line_rasterizer import dda_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  dda_in_if.sink                    cmd,
  dda_out_if.source                 pix,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [REG_BITS-1:0]       cfg_data
);

  dda_cmd_t    ctl;
  dda_stat_t   stat;
  dda_result_t result;
  logic        dividing;

  dda_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.valid),
    .in_opcode (cmd.opcode),
    .in_ready  (cmd.ready),
    .out_valid (pix.valid),
    .out_ready (pix.ready),
    .stat      (stat),
    .cmd       (ctl),
    .dividing  (dividing)
  );

  dda_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (ctl),
    .stat      (stat),
    .first_x   (cmd.first_x),
    .first_y   (cmd.first_y),
    .second_x  (cmd.second_x),
    .second_y  (cmd.second_y),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .result    (result)
  );

  assign pix.pixel_x     = result.pixel_x;
  assign pix.pixel_y     = result.pixel_y;
  assign pix.visible     = result.visible;
  assign pix.last        = result.last;
  assign pix.line_active = result.line_active;

  // Divider finishes only while the controller waits for it
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    stat.div_done |-> dividing)
    else $error("divider done outside slope wait");

  // A load always enters the slope wait
  a_load_waits: assert property (@(posedge clk) disable iff (rst)
    ctl.load |=> dividing)
    else $error("load did not start slope wait");

  // No word is taken while the slope is pending
  a_no_accept_div: assert property (@(posedge clk) disable iff (rst)
    dividing |-> !cmd.ready)
    else $error("input accepted during slope division");

  // A step with no line gives an all-zero word
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    (pix.valid && !pix.line_active) |->
      (pix.pixel_x == '0 && pix.pixel_y == '0 && !pix.visible && !pix.last))
    else $error("idle step word carries nonzero fields");

endmodule

### rtl/dda_divider.sv
module dda_divider import dda_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [QUO_BITS-1:0]   dividend,
  input  logic [COORD_BITS-1:0] divisor,
  output logic                  done,
  output logic [QUO_BITS-1:0]   quotient
);

  logic [QUO_BITS-1:0]   work;
  logic [COORD_BITS-1:0] rem;
  logic [COORD_BITS-1:0] dsr;
  logic [CNT_BITS-1:0]   count;
  logic                  running;
  logic [COORD_BITS:0]   shifted;
  logic [COORD_BITS:0]   diff;
  logic                  fits;

  // Trial subtract of the divisor from the partial remainder
  assign shifted = {rem, work[QUO_BITS-1]};
  assign diff    = shifted - {1'b0, dsr};
  assign fits    = shifted >= {1'b0, dsr};

  // Shift one quotient bit in per cycle, dividend bits out at the top
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        count   <= CNT_BITS'(QUO_BITS);
        work    <= dividend;
        rem     <= '0;
        dsr     <= divisor;
      end else if (running) begin
        work  <= {work[QUO_BITS-2:0], fits};
        rem   <= fits ? diff[COORD_BITS-1:0] : shifted[COORD_BITS-1:0];
        count <= count - CNT_BITS'(1);
        if (count == CNT_BITS'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign quotient = work;

endmodule

### rtl/dda_datapath.sv
module dda_datapath import dda_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  dda_cmd_t                  cmd,
  output dda_stat_t                 stat,
  input  logic [COORD_BITS-1:0]     first_x,
  input  logic [COORD_BITS-1:0]     first_y,
  input  logic [COORD_BITS-1:0]     second_x,
  input  logic [COORD_BITS-1:0]     second_y,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [REG_BITS-1:0]       cfg_data,
  output dda_result_t               result
);

  logic [REG_BITS-1:0]   screen_width;
  logic [REG_BITS-1:0]   screen_height;
  logic [COORD_BITS-1:0] current_x;
  logic [COORD_BITS-1:0] end_x;
  logic [ACC_BITS-1:0]   y_accumulator;
  logic [ACC_BITS-1:0]   slope;
  logic                  busy;
  logic                  neg;
  logic                  dx_zero;

  logic                  a_first;
  logic [COORD_BITS-1:0] sx, sy, ex, ey, dx, dy_mag;
  logic [QUO_BITS-1:0]   dividend;
  logic [QUO_BITS-1:0]   quotient;
  logic [ACC_BITS-1:0]   q_ext;
  logic [ACC_BITS-1:0]   round_sum;
  logic [COORD_BITS-1:0] py;
  logic                  is_last;
  dda_result_t           step_res;

  // Order endpoints so the start has the smaller x; ties take the second
  assign a_first  = first_x < second_x;
  assign sx       = a_first ? first_x  : second_x;
  assign sy       = a_first ? first_y  : second_y;
  assign ex       = a_first ? second_x : first_x;
  assign ey       = a_first ? second_y : first_y;
  assign dx       = ex - sx;
  assign dy_mag   = (ey < sy) ? (sy - ey) : (ey - sy);
  assign dividend = {dy_mag, {FRAC_BITS{1'b0}}};

  dda_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.load),
    .dividend (dividend),
    .divisor  (dx),
    .done     (stat.div_done),
    .quotient (quotient)
  );

  assign q_ext = {1'b0, quotient};

  // Current pixel: round y half up, clip against the screen
  assign round_sum = y_accumulator + HALF_LSB;
  assign py        = round_sum[FRAC_BITS +: COORD_BITS];
  assign is_last   = current_x == end_x;

  always_comb begin
    step_res = '0;
    if (busy) begin
      step_res.pixel_x     = current_x;
      step_res.pixel_y     = py;
      step_res.visible     = ({1'b0, current_x} < screen_width) &&
                             ({1'b0, py} < screen_height);
      step_res.last        = is_last;
      step_res.line_active = 1'b1;
    end
  end

  // Screen size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SCREEN_RESET;
      screen_height <= SCREEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        CFG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Line state: load, commit the slope, advance on each step before the last pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (cmd.load) begin
      busy <= 1'b0;
    end else if (cmd.commit) begin
      busy <= 1'b1;
    end else if (cmd.step && busy && is_last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      current_x     <= sx;
      end_x         <= ex;
      y_accumulator <= {1'b0, sy, {FRAC_BITS{1'b0}}};
      neg           <= ey < sy;
      dx_zero       <= dx == '0;
    end else if (cmd.commit) begin
      slope <= dx_zero ? '0 : (neg ? (~q_ext + ACC_BITS'(1)) : q_ext);
    end else if (cmd.step && busy && !is_last) begin
      current_x     <= current_x + COORD_BITS'(1);
      y_accumulator <= y_accumulator + slope;
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      result <= step_res;
    end
  end

endmodule

### rtl/dda_ctrl.sv
module dda_ctrl import dda_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_opcode,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  dda_stat_t stat,
  output dda_cmd_t  cmd,
  output logic      dividing
);

  typedef enum logic [1:0] {
    S_RUN = 2'b01,
    S_DIV = 2'b10
  } state_t;

  state_t state, state_next;
  logic   accept;

  // Take a word when running and the output register is free or draining
  assign in_ready   = (state == S_RUN) && (!out_valid || out_ready);
  assign accept     = in_valid && in_ready;
  assign cmd.load   = accept && (in_opcode == OP_LOAD);
  assign cmd.step   = accept && (in_opcode == OP_STEP);
  assign cmd.commit = (state == S_DIV) && stat.div_done;
  assign dividing   = state == S_DIV;

  always_comb begin
    state_next = state;
    case (state)
      S_RUN:   if (cmd.load) state_next = S_DIV;
      S_DIV:   if (stat.div_done) state_next = S_RUN;
      default: state_next = S_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_RUN;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.step) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
